>>> rtl/primed_moving_average_top_macros.svh
// Assertion macros shared by the checker of primed_moving_average_top.
`ifndef PRIMED_MOVING_AVERAGE_TOP_MACROS_SVH
`define PRIMED_MOVING_AVERAGE_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/pma_pkg.sv
package pma_pkg;

  // Ring capacity and derived widths
  localparam int MaxWindow   = 256;
  localparam int DataW       = 32;
  localparam int CfgW        = 9;
  localparam int SlotW       = $clog2(MaxWindow);
  localparam int SizeW       = $clog2(MaxWindow + 1);
  localparam int SumW        = DataW + SlotW;
  localparam int MulW        = SizeW + 1 + DataW;
  localparam int CmpW        = (CfgW > SizeW) ? CfgW : SizeW;
  localparam logic [CfgW-1:0] WindowReset = CfgW'(16);

  // Front-to-back queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Operation decided by the front end
  typedef enum logic [1:0] {
    OpClear,
    OpPrime,
    OpUpdate
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] sample;
  } item_t;

  // Window size as used: zero acts as one, large values saturate
  function automatic logic [SizeW-1:0] eff_size(input logic [CfgW-1:0] w);
    logic [CmpW-1:0] ext;
    logic [SizeW-1:0] ret;
    ext = CmpW'(w);
    if (ext == '0) begin
      ret = SizeW'(1);
    end else if (ext > CmpW'(MaxWindow)) begin
      ret = SizeW'(MaxWindow);
    end else begin
      ret = SizeW'(ext);
    end
    return ret;
  endfunction

endpackage

>>> rtl/pma_front.sv
module pma_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [pma_pkg::DataW-1:0]    s_axis_tdata_i,  // [31:0] sample
  input  logic                         s_axis_tuser_i,  // [0] mode
  input  logic                         cfg_we_i,
  input  logic [pma_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         push_valid_o,
  output pma_pkg::item_t               push_item_o,
  input  logic                         push_ready_i,
  output logic [pma_pkg::SizeW-1:0]    n_o
);

  logic                      cleared_q, cleared_d;
  logic [pma_pkg::CfgW-1:0]  window_q, window_d;
  logic                      accept;

  // Accept whenever the queue has room
  assign s_axis_tready_o = push_ready_i;
  assign push_valid_o    = s_axis_tvalid_i;
  assign accept          = s_axis_tvalid_i & push_ready_i;
  assign n_o             = pma_pkg::eff_size(window_q);

  // Classify: clear, first sample after a clear, or ordinary sample
  always_comb begin
    push_item_o.sample = s_axis_tdata_i;
    if (s_axis_tuser_i) begin
      push_item_o.op = pma_pkg::OpClear;
    end else if (cleared_q) begin
      push_item_o.op = pma_pkg::OpPrime;
    end else begin
      push_item_o.op = pma_pkg::OpUpdate;
    end
  end

  // Unprimed flag and window register; a window write also unprimes
  always_comb begin
    cleared_d = cleared_q;
    window_d  = window_q;
    if (cfg_we_i) begin
      window_d  = cfg_wdata_i;
      cleared_d = 1'b1;
    end else if (accept) begin
      cleared_d = s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cleared_q <= 1'b1;
      window_q  <= pma_pkg::WindowReset;
    end else begin
      cleared_q <= cleared_d;
      window_q  <= window_d;
    end
  end

endmodule

>>> rtl/pma_queue.sv
module pma_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  pma_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output pma_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);

  pma_pkg::item_t              mem_q [pma_pkg::QDepth];
  logic [pma_pkg::QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [pma_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != pma_pkg::QCntW'(pma_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == pma_pkg::QPtrW'(pma_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == pma_pkg::QPtrW'(pma_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/pma_back.sv
module pma_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pma_pkg::SizeW-1:0]   n_i,
  input  logic                        pop_valid_i,
  input  pma_pkg::item_t              pop_item_i,
  output logic                        pop_ready_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [pma_pkg::DataW-1:0]   m_axis_tdata_o   // [31:0] average
);

  localparam int DataW = pma_pkg::DataW;
  localparam int SumW  = pma_pkg::SumW;
  localparam int SlotW = pma_pkg::SlotW;
  localparam int SizeW = pma_pkg::SizeW;
  localparam int CntW  = $clog2(SumW);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSum  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic                    first_q, first_d;
  logic [DataW-1:0]        prime_q, prime_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [DataW-1:0]        x_q, x_d;
  logic                    neg_q, neg_d;
  logic [SumW-1:0]         dvd_q, dvd_d;
  logic [SizeW-1:0]        rem_q, rem_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [DataW-1:0]        res_q, res_d;
  logic                    outv_q, outv_d;
  logic [DataW-1:0]        outd_q, outd_d;

  // Sample ring
  logic [DataW-1:0]        ring_q [pma_pkg::MaxWindow];
  logic [DataW-1:0]        rdata_q;
  logic [SlotW-1:0]        raddr;
  logic                    ring_we;
  logic [SlotW-1:0]        ring_waddr;
  logic [DataW-1:0]        ring_wdata;

  logic signed [pma_pkg::MulW-1:0] prime_prod;
  logic [SizeW:0]          n_ext, slot_ext, slot_nxt;
  logic                    slot_wrap;
  logic [DataW-1:0]        oldest;
  logic [SizeW:0]          shifted, diff;
  logic                    ge;
  logic [SumW-1:0]         dvd_step;
  logic [DataW-1:0]        q_low;
  logic                    out_load;

  assign prime_prod = $signed({1'b0, n_i}) * $signed(pop_item_i.sample);
  assign n_ext      = {1'b0, n_i};
  assign slot_ext   = (SizeW + 1)'(slot_q);
  assign slot_nxt   = slot_ext + 1'b1;
  assign slot_wrap  = (slot_ext >= n_ext);
  assign oldest     = first_q ? prime_q : rdata_q;

  // One restoring division step: one quotient bit per cycle
  assign shifted  = {rem_q, dvd_q[SumW-1]};
  assign diff     = shifted - n_ext;
  assign ge       = (shifted >= n_ext);
  assign dvd_step = {dvd_q[SumW-2:0], ge};
  assign q_low    = dvd_step[DataW-1:0];

  assign out_load        = (state_q == StDone) && (!outv_q || m_axis_tready_i);
  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o  = outd_q;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    first_d     = first_q;
    prime_d     = prime_q;
    sum_d       = sum_q;
    x_d         = x_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    pop_ready_o = 1'b0;
    raddr       = slot_q;
    ring_we     = 1'b0;
    ring_waddr  = slot_q;
    ring_wdata  = x_q;
    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          pop_ready_o = 1'b1;
          case (pop_item_i.op)
            pma_pkg::OpClear: begin
              res_d   = '0;
              state_d = StDone;
            end
            pma_pkg::OpPrime: begin
              // every slot counts as the first sample
              prime_d    = pop_item_i.sample;
              sum_d      = prime_prod[SumW-1:0];
              ring_we    = 1'b1;
              ring_waddr = '0;
              ring_wdata = pop_item_i.sample;
              if (n_i == SizeW'(1)) begin
                slot_d  = '0;
                first_d = 1'b0;
              end else begin
                slot_d  = SlotW'(1);
                first_d = 1'b1;
              end
              res_d   = pop_item_i.sample;
              state_d = StDone;
            end
            pma_pkg::OpUpdate: begin
              // fetch the oldest slot
              x_d = pop_item_i.sample;
              if (slot_wrap) begin
                slot_d  = '0;
                first_d = 1'b0;
                raddr   = '0;
              end
              state_d = StSum;
            end
            default: begin
              res_d   = '0;
              state_d = StDone;
            end
          endcase
        end
      end
      StSum: begin
        // replace oldest sample in the running sum and the ring
        sum_d   = sum_q - $signed({{(SumW-DataW){oldest[DataW-1]}}, oldest})
                        + $signed({{(SumW-DataW){x_q[DataW-1]}}, x_q});
        ring_we = 1'b1;
        if (slot_nxt >= n_ext) begin
          slot_d  = '0;
          first_d = 1'b0;
        end else begin
          slot_d = slot_nxt[SlotW-1:0];
        end
        state_d = StLoad;
      end
      StLoad: begin
        // divide the magnitude, fix the sign at the end
        neg_d   = sum_q[SumW-1];
        dvd_d   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        dvd_d = dvd_step;
        rem_d = ge ? diff[SizeW-1:0] : shifted[SizeW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          res_d   = neg_q ? (DataW'(0) - q_low) : q_low;
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register
  always_comb begin
    outv_d = outv_q;
    outd_d = outd_q;
    if (out_load) begin
      outv_d = 1'b1;
      outd_d = res_q;
    end else if (m_axis_tready_i) begin
      outv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slot_q  <= '0;
      first_q <= 1'b1;
      prime_q <= '0;
      sum_q   <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      first_q <= first_d;
      prime_q <= prime_d;
      sum_q   <= sum_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    neg_q  <= neg_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    outd_q <= outd_d;
  end

  // Ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ring_waddr] <= ring_wdata;
    end
    rdata_q <= ring_q[raddr];
  end

endmodule

>>> rtl/primed_moving_average_top.sv
// Sliding-window average of signed 32-bit samples over the last window_size
// samples (1..256, written on cfg_wdata_i; 0 acts as 1, larger values as 256).
// Set s_axis_tuser_i to clear the filter (result 0); the first sample after a
// clear, reset or window write primes the whole window and is returned as is.
// Later samples return the window sum divided by the window size, truncated
// toward zero. A clear or priming item passes through the queue, and its
// result then loads the output register. An ordinary sample passes through
// the queue while the oldest slot is read, then updates the running sum,
// loads the divider, runs the bit-serial divider that produces one quotient
// bit per cycle over the 40-bit sum, and loads the output register. The
// back end takes a new item from the queue only after the last one has
// left it for the output register. A two-item queue lets inputs be taken
// while the back end is busy, and a finished result waits in the output
// register while the back end works on the next item; a second finished
// result waits in the back end until the first one is taken.
module primed_moving_average_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [pma_pkg::DataW-1:0]  s_axis_tdata_i,   // [31:0] sample
  input  logic                       s_axis_tuser_i,   // [0] mode
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [pma_pkg::DataW-1:0]  m_axis_tdata_o,   // [31:0] average
  input  logic                       cfg_we_i,
  input  logic [pma_pkg::CfgW-1:0]   cfg_wdata_i       // window_size
);

  logic                        push_valid, push_ready;
  pma_pkg::item_t              push_item;
  logic                        pop_valid, pop_ready;
  pma_pkg::item_t              pop_item;
  logic [pma_pkg::SizeW-1:0]   n;

  // Accept and classify
  pma_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push_valid_o    (push_valid),
    .push_item_o     (push_item),
    .push_ready_i    (push_ready),
    .n_o             (n)
  );

  // Decoupling queue
  pma_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Ring, running sum and divider
  pma_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .n_i             (n),
    .pop_valid_i     (pop_valid),
    .pop_item_i      (pop_item),
    .pop_ready_o     (pop_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/pma_checker.sv
`include "primed_moving_average_top_macros.svh"

module pma_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [pma_pkg::DataW-1:0]  m_axis_tdata_o
);

  // Items in flight: queue entries, one in the back end, one in the output
  localparam int MaxInFlight = pma_pkg::QDepth + 2;
  localparam int FlightW     = $clog2(MaxInFlight + 2);

  logic [FlightW-1:0] flight_q, flight_d;
  logic               in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  always_comb begin
    flight_d = flight_q;
    if (in_acc && !out_acc) begin
      flight_d = flight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      flight_d = flight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_d;
    end
  end

  `PMA_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")
  `PMA_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result dropped or changed")
  `PMA_ASSERT(a_out_has_item, m_axis_tvalid_o |-> flight_q != '0, "result with no item in flight")
  `PMA_ASSERT(a_flight_bound, flight_q <= FlightW'(MaxInFlight), "more items in flight than storage")
  `PMA_ASSERT(a_stall_full, !s_axis_tready_o |-> flight_q >= FlightW'(pma_pkg::QDepth), "input stalled with queue not full")

endmodule

bind primed_moving_average_top pma_checker u_pma_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
